[hdl/json_string_unescape_utf8_defines.svh]
// assertion macros for the json string unescaper
// used by json_string_unescape_utf8 to check its own logic; needs clk and rst_n in scope
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication, disabled in reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/jsu_pkg.sv]
// shared types, character codes and hex digit decode for the json unescaper
// no dependencies
package jsu_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
  localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;

  localparam logic [15:0] SURR_MASK = 16'hFC00;
  localparam logic [15:0] SURR_HIGH = 16'hD800;
  localparam logic [15:0] CP_ONE_MAX = 16'h0080;
  localparam logic [15:0] CP_TWO_MAX = 16'h0800;

  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              string_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              bad_escape;
  } out_item_t;

  // {ok, value}; a non-hex byte gives value 0
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

[hdl/jsu_in_if.sv]
// input channel: escaped string bytes with valid/ready handshake
// depends on jsu_pkg
interface jsu_in_if;
  import jsu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/jsu_out_if.sv]
// result channel: unescaped utf-8 bytes with valid/ready handshake
// depends on jsu_pkg
interface jsu_out_if;
  import jsu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/json_string_unescape_utf8.sv]
// json string body unescaper producing utf-8, one input byte per transfer
// depends on jsu_pkg, jsu_in_if, jsu_out_if, json_string_unescape_utf8_defines.svh
//
// in_ch takes one escaped body byte per transfer with string_end on the last
// byte of a string. out_ch gives the unescaped bytes, zero to four per input
// byte, with run_last on the final byte that an input caused and bad_escape on
// bytes from malformed or unfinished escapes.
// An accepted byte waits in the input register until the result register is free;
// then it is decoded, the escape state is updated and up to four result bytes are
// loaded into the result register, from which the first result is offered.
// The result register drains one byte per cycle while out_ch is ready: an input
// that yields at most one byte then sustains one transfer per cycle on both sides,
// and an input yielding several bytes holds the decode step until its last byte
// transfers. Inputs yielding nothing pass through the decode step without loading
// a result.
// While out_ch is stalled the result register holds, and the input register
// still takes one more byte before in_ch ready drops.
// Reset empties both registers and returns the decoder to literal mode.
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8 (
  input logic      clk,
  input logic      rst_n,
  jsu_in_if.sink   in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_ESC     = 3'd1,
    M_HEX1    = 3'd2,
    M_SURR_BS = 3'd3,
    M_SURR_U  = 3'd4,
    M_HEX2    = 3'd5
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [15:0] high_r, high_nxt;
  logic        fault_r, fault_nxt;

  logic              item_valid_r;
  logic [BYTE_W-1:0] item_byte_r;
  logic              item_end_r;

  logic              bnd_valid_r;
  logic [BYTE_W-1:0] bnd_byte_r [MAX_RES];
  logic              bnd_bad_r  [MAX_RES];
  logic [RES_IDX_W-1:0] bnd_last_r;
  logic [RES_IDX_W-1:0] bnd_idx_r;

  logic [BYTE_W-1:0] res_byte [MAX_RES];
  logic              res_bad  [MAX_RES];
  logic [RES_IDX_W:0] n;
  logic [RES_IDX_W-1:0] res_last;

  logic        in_xfer, out_xfer, bnd_free, process;
  logic [4:0]  dig;
  logic [15:0] hex_shift;
  logic [20:0] pair_cp;

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign bnd_free = !bnd_valid_r || (out_ch.ready && (bnd_idx_r == bnd_last_r));
  assign process  = item_valid_r && bnd_free;
  assign in_ch.ready = !item_valid_r || process;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign out_ch.valid = bnd_valid_r;
  assign out_ch.data.out_byte   = bnd_byte_r[bnd_idx_r];
  assign out_ch.data.bad_escape = bnd_bad_r[bnd_idx_r];
  assign out_ch.data.run_last   = (bnd_idx_r == bnd_last_r);

  assign dig       = hex_decode(item_byte_r);
  assign hex_shift = {hex_r[11:0], dig[3:0]};
  assign pair_cp   = {5'({1'b0, high_r[9:6]} + 5'd1), high_r[5:0], hex_shift[9:0]};
  assign res_last  = RES_IDX_W'(n - 1'b1);

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_byte[i] = '0;
      res_bad[i]  = 1'b0;
    end
    n         = '0;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    hex_nxt   = hex_r;
    high_nxt  = high_r;
    fault_nxt = fault_r;

    unique case (mode_r)
      M_ESC: begin
        mode_nxt = M_NORMAL;
        n = 3'd1;
        res_bad[0] = 1'b0;
        case (item_byte_r)
          CH_LOW_R:  res_byte[0] = CH_CR;
          CH_LOW_N:  res_byte[0] = CH_LF;
          CH_BSLASH: res_byte[0] = CH_BSLASH;
          CH_SLASH:  res_byte[0] = CH_SLASH;
          CH_QUOTE:  res_byte[0] = CH_QUOTE;
          CH_LOW_F:  res_byte[0] = CH_FF;
          CH_LOW_B:  res_byte[0] = CH_BS;
          CH_LOW_T:  res_byte[0] = CH_TAB;
          CH_LOW_U: begin
            n         = 3'd0;
            mode_nxt  = M_HEX1;
            count_nxt = 2'd0;
            hex_nxt   = 16'd0;
            fault_nxt = 1'b0;
          end
          default: begin
            res_byte[0] = CH_QMARK;
            res_bad[0]  = 1'b1;
          end
        endcase
      end
      M_HEX1, M_HEX2: begin
        fault_nxt = fault_r | ~dig[4];
        hex_nxt   = hex_shift;
        if (count_r != 2'd3) begin
          count_nxt = count_r + 2'd1;
        end else begin
          count_nxt = 2'd0;
          mode_nxt  = M_NORMAL;
          if (mode_r == M_HEX2) begin
            n = 3'd4;
            res_byte[0] = LEAD_FOUR | {5'd0, pair_cp[20:18]};
            res_byte[1] = CONT_MARK | {2'd0, pair_cp[17:12]};
            res_byte[2] = CONT_MARK | {2'd0, pair_cp[11:6]};
            res_byte[3] = CONT_MARK | {2'd0, pair_cp[5:0]};
          end else if ((hex_shift & SURR_MASK) == SURR_HIGH) begin
            high_nxt = hex_shift;
            mode_nxt = M_SURR_BS;
          end else if (hex_shift < CP_ONE_MAX) begin
            n = 3'd1;
            res_byte[0] = hex_shift[7:0];
          end else if (hex_shift < CP_TWO_MAX) begin
            n = 3'd2;
            res_byte[0] = LEAD_TWO | {3'd0, hex_shift[10:6]};
            res_byte[1] = CONT_MARK | {2'd0, hex_shift[5:0]};
          end else begin
            n = 3'd3;
            res_byte[0] = LEAD_THREE | {4'd0, hex_shift[15:12]};
            res_byte[1] = CONT_MARK | {2'd0, hex_shift[11:6]};
            res_byte[2] = CONT_MARK | {2'd0, hex_shift[5:0]};
          end
          for (int i = 0; i < MAX_RES; i++) begin
            res_bad[i] = fault_r | ~dig[4];
          end
        end
      end
      M_SURR_BS: begin
        if (item_byte_r == CH_BSLASH) begin
          mode_nxt = M_SURR_U;
        end else begin
          n = 3'd1;
          res_byte[0] = CH_QMARK;
          res_bad[0]  = fault_r;
          mode_nxt    = M_NORMAL;
        end
      end
      M_SURR_U: begin
        if (item_byte_r == CH_LOW_U) begin
          mode_nxt  = M_HEX2;
          count_nxt = 2'd0;
          hex_nxt   = 16'd0;
        end else begin
          n = 3'd1;
          res_byte[0] = CH_QMARK;
          res_bad[0]  = fault_r;
          if (item_byte_r == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            mode_nxt = M_NORMAL;
            n = 3'd2;
            res_byte[1] = item_byte_r;
          end
        end
      end
      default: begin
        mode_nxt = M_NORMAL;
        if (item_byte_r == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          n = 3'd1;
          res_byte[0] = item_byte_r;
        end
      end
    endcase

    if (item_end_r) begin
      // string ended inside an escape
      if (mode_nxt != M_NORMAL) begin
        res_byte[n[RES_IDX_W-1:0]] = CH_QMARK;
        res_bad[n[RES_IDX_W-1:0]]  = 1'b1;
        n = n + 1'b1;
      end
      mode_nxt  = M_NORMAL;
      count_nxt = 2'd0;
      hex_nxt   = 16'd0;
      high_nxt  = 16'd0;
      fault_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      bnd_valid_r  <= 1'b0;
      bnd_idx_r    <= '0;
      bnd_last_r   <= '0;
      mode_r       <= M_NORMAL;
      count_r      <= 2'd0;
      hex_r        <= 16'd0;
      high_r       <= 16'd0;
      fault_r      <= 1'b0;
    end else begin
      if (in_xfer) begin
        item_valid_r <= 1'b1;
        item_byte_r  <= in_ch.data.in_byte;
        item_end_r   <= in_ch.data.string_end;
      end else if (process) begin
        item_valid_r <= 1'b0;
      end

      if (process) begin
        mode_r      <= mode_nxt;
        count_r     <= count_nxt;
        hex_r       <= hex_nxt;
        high_r      <= high_nxt;
        fault_r     <= fault_nxt;
        bnd_valid_r <= (n != '0);
        bnd_last_r  <= res_last;
        bnd_idx_r   <= '0;
        for (int i = 0; i < MAX_RES; i++) begin
          bnd_byte_r[i] <= res_byte[i];
          bnd_bad_r[i]  <= res_bad[i];
        end
      end else if (out_xfer) begin
        if (bnd_idx_r == bnd_last_r) begin
          bnd_valid_r <= 1'b0;
        end else begin
          bnd_idx_r <= bnd_idx_r + 1'b1;
        end
      end
    end
  end

  `JSU_ASSERT_NOW(a_ready_when_empty, !item_valid_r, in_ch.ready,
    "input register empty but not ready")
  `JSU_ASSERT_NEXT(a_run_continues, out_xfer && !out_ch.data.run_last, out_ch.valid,
    "result run broken before its last byte")
  `JSU_ASSERT_NOW(a_count_in_hex, count_r != 2'd0, mode_r == M_HEX1 || mode_r == M_HEX2,
    "digit count set outside a hex group")
  `JSU_ASSERT_NEXT(a_end_clears, process && item_end_r,
    mode_r == M_NORMAL && count_r == 2'd0 && !fault_r,
    "decoder state not cleared at string end")

endmodule

[dv/utf8_unescape_check.sv]
// checker for the json string unescaper: watches both channels, predicts the utf-8 bytes
// for every input transfer and compares each result transfer field by field
// depends on jsu_pkg, jsu_in_if, jsu_out_if
module utf8_unescape_check (
  input  logic clk,
  input  logic rst_n,
  jsu_in_if    in_mon,
  jsu_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   bytes_checked,
  output int   pairs_seen,
  output int   flagged_seen
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_LITERAL     = 3'd0,
    MODE_ESCAPE      = 3'd1,
    MODE_HEX_FIRST   = 3'd2,
    MODE_SURR_BSLASH = 3'd3,
    MODE_SURR_U      = 3'd4,
    MODE_HEX_SECOND  = 3'd5
  } unescape_mode_e;

  unescape_mode_e mode_q;
  logic [1:0]     digit_cnt;
  logic [15:0]    code_acc;
  logic [15:0]    high_surr;
  logic           digit_bad;
  out_item_t      utf8_expected[$];
  int             mismatches = 0;
  int             checked = 0;
  int             pairs = 0;
  int             flagged = 0;

  function automatic void clear_decoder();
    mode_q    = MODE_LITERAL;
    digit_cnt = 2'd0;
    code_acc  = 16'd0;
    high_surr = 16'd0;
    digit_bad = 1'b0;
  endfunction

  function automatic void push_utf8(input logic [7:0] b, input logic bad);
    out_item_t r;
    r.out_byte   = b;
    r.run_last   = 1'b0;
    r.bad_escape = bad;
    utf8_expected.push_back(r);
  endfunction

  function automatic void literal_byte(input logic [7:0] b);
    if (b == CH_BSLASH) begin
      mode_q = MODE_ESCAPE;
    end else begin
      push_utf8(b, 1'b0);
    end
  endfunction

  // returns 1 for a hex digit; anything else reads as zero
  function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
    v = 4'd0;
    if (b >= "0" && b <= "9") begin
      v = 4'(b - "0");
      return 1'b1;
    end
    if (b >= "A" && b <= "F") begin
      v = 4'(b - "A" + 8'd10);
      return 1'b1;
    end
    if (b >= "a" && b <= "f") begin
      v = 4'(b - "a" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_code_point(input logic [15:0] cp, input logic bad);
    if (cp < 16'h0080) begin
      push_utf8(cp[7:0], bad);
    end else if (cp < 16'h0800) begin
      push_utf8({3'b110, cp[10:6]}, bad);
      push_utf8({2'b10, cp[5:0]}, bad);
    end else begin
      push_utf8({4'b1110, cp[15:12]}, bad);
      push_utf8({2'b10, cp[11:6]}, bad);
      push_utf8({2'b10, cp[5:0]}, bad);
    end
  endfunction

  // low half is taken as is, only its ten low bits count
  function automatic void push_pair(input logic bad);
    logic [20:0] cp;
    cp[20:16] = {1'b0, high_surr[9:6]} + 5'd1;
    cp[15:10] = high_surr[5:0];
    cp[9:0]   = code_acc[9:0];
    push_utf8({5'b11110, cp[20:18]}, bad);
    push_utf8({2'b10, cp[17:12]}, bad);
    push_utf8({2'b10, cp[11:6]}, bad);
    push_utf8({2'b10, cp[5:0]}, bad);
    pairs++;
  endfunction

  function automatic void unescape_byte(input in_item_t it);
    logic [3:0] nib;
    bit         ok;
    int         first;
    out_item_t  tail;
    first = utf8_expected.size();
    case (mode_q)
      MODE_ESCAPE: begin
        mode_q = MODE_LITERAL;
        case (it.in_byte)
          CH_LOW_R:  push_utf8(CH_CR, 1'b0);
          CH_LOW_N:  push_utf8(CH_LF, 1'b0);
          CH_BSLASH: push_utf8(CH_BSLASH, 1'b0);
          CH_SLASH:  push_utf8(CH_SLASH, 1'b0);
          CH_QUOTE:  push_utf8(CH_QUOTE, 1'b0);
          CH_LOW_F:  push_utf8(CH_FF, 1'b0);
          CH_LOW_B:  push_utf8(CH_BS, 1'b0);
          CH_LOW_T:  push_utf8(CH_TAB, 1'b0);
          CH_LOW_U: begin
            mode_q    = MODE_HEX_FIRST;
            digit_cnt = 2'd0;
            code_acc  = 16'd0;
            digit_bad = 1'b0;
          end
          default:   push_utf8(CH_QMARK, 1'b1);
        endcase
      end
      MODE_HEX_FIRST, MODE_HEX_SECOND: begin
        ok = hex_nibble(it.in_byte, nib);
        if (!ok) digit_bad = 1'b1;
        code_acc = {code_acc[11:0], nib};
        if (digit_cnt != 2'd3) begin
          digit_cnt++;
        end else begin
          digit_cnt = 2'd0;
          if (mode_q == MODE_HEX_SECOND) begin
            push_pair(digit_bad);
            mode_q = MODE_LITERAL;
          end else if ((code_acc & SURR_MASK) == SURR_HIGH) begin
            high_surr = code_acc;
            mode_q    = MODE_SURR_BSLASH;
          end else begin
            push_code_point(code_acc, digit_bad);
            mode_q = MODE_LITERAL;
          end
        end
      end
      MODE_SURR_BSLASH: begin
        if (it.in_byte == CH_BSLASH) begin
          mode_q = MODE_SURR_U;
        end else begin
          push_utf8(CH_QMARK, digit_bad);
          mode_q = MODE_LITERAL;
        end
      end
      MODE_SURR_U: begin
        if (it.in_byte == CH_LOW_U) begin
          mode_q    = MODE_HEX_SECOND;
          digit_cnt = 2'd0;
          code_acc  = 16'd0;
        end else begin
          push_utf8(CH_QMARK, digit_bad);
          mode_q = MODE_LITERAL;
          literal_byte(it.in_byte);
        end
      end
      default: begin
        mode_q = MODE_LITERAL;
        literal_byte(it.in_byte);
      end
    endcase
    if (it.string_end) begin
      if (mode_q != MODE_LITERAL) push_utf8(CH_QMARK, 1'b1);
      clear_decoder();
    end
    if (utf8_expected.size() > first) begin
      tail = utf8_expected.pop_back();
      tail.run_last = 1'b1;
      utf8_expected.push_back(tail);
    end
  endfunction

  function automatic void compare_result(input out_item_t got);
    out_item_t want;
    if (utf8_expected.size() == 0) begin
      $error("result byte %h arrived with nothing expected", got.out_byte);
      mismatches++;
      return;
    end
    want = utf8_expected.pop_front();
    checked++;
    if (want.bad_escape) flagged++;
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
      mismatches++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %b, got %b", want.run_last, got.run_last);
      mismatches++;
    end
    if (got.bad_escape !== want.bad_escape) begin
      $error("bad_escape: expected %b, got %b", want.bad_escape, got.bad_escape);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      utf8_expected.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) unescape_byte(in_mon.data);
      if (out_mon.valid && out_mon.ready) compare_result(out_mon.data);
    end
    fail_count    <= mismatches;
    pending       <= utf8_expected.size();
    bytes_checked <= checked;
    pairs_seen    <= pairs;
    flagged_seen  <= flagged;
  end

endmodule

[dv/tb.sv]
// testbench top for json_string_unescape_utf8: drives escaped string bytes with random
// gaps and result stalls, a long hold-off and drains; utf8_unescape_check does the checking
// depends on jsu_pkg, jsu_in_if, jsu_out_if, json_string_unescape_utf8, utf8_unescape_check
module tb;
  import jsu_pkg::*;

  localparam int ITEM_TARGET = 370;
  localparam int HOLD_CYCLES = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;

  localparam logic [7:0] ESC_LETTERS [8] = '{
    CH_LOW_R, CH_LOW_N, CH_BSLASH, CH_SLASH, CH_QUOTE, CH_LOW_F, CH_LOW_B, CH_LOW_T
  };

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n;
  bit   burst_mode = 1'b0;
  bit   hold_req = 1'b0;
  int   bytes_sent = 0;
  int   idle_cycles;
  int   fail_count;
  int   pending;
  int   bytes_checked;
  int   pairs_seen;
  int   flagged_seen;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_unescape_check utf8_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked),
    .pairs_seen    (pairs_seen),
    .flagged_seen  (flagged_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic byte_q_t text_bytes(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    return 8'($urandom_range(8'h67, 8'hFF));
  endfunction

  function automatic logic [15:0] high_surrogate();
    return SURR_HIGH | 16'($urandom_range(0, 16'h03FF));
  endfunction

  // backslash, u and four hex digits in mixed case
  function automatic void push_uescape(ref byte_q_t seq, input logic [15:0] cp);
    logic [3:0] nib;
    seq.push_back(CH_BSLASH);
    seq.push_back(CH_LOW_U);
    for (int i = 3; i >= 0; i--) begin
      nib = cp[i*4 +: 4];
      if (nib < 4'd10) begin
        seq.push_back(8'("0" + nib));
      end else begin
        seq.push_back(8'(($urandom_range(0, 1) ? "A" : "a") + nib - 8'd10));
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{in_byte: b, string_end: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_seq(input byte_q_t seq, input logic end_here);
    foreach (seq[i]) send_byte(seq[i], end_here && (i == seq.size() - 1));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_token();
    byte_q_t     seq;
    int          pick;
    int          keep;
    logic [15:0] cp;
    logic [7:0]  b;
    logic        end_here;
    pick = $urandom_range(0, 99);
    end_here = ($urandom_range(0, 11) == 0);
    if (pick < 28) begin
      seq.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 43) begin
      seq.push_back(CH_BSLASH);
      seq.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
    end else if (pick < 63) begin
      case ($urandom_range(0, 2))
        0: cp = 16'($urandom_range(0, 16'h007F));
        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
        default: begin
          do cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          while ((cp & SURR_MASK) == SURR_HIGH);
        end
      endcase
      push_uescape(seq, cp);
    end else if (pick < 78) begin
      push_uescape(seq, high_surrogate());
      push_uescape(seq, 16'($urandom));
    end else if (pick < 85) begin
      // high surrogate with no low half behind it
      push_uescape(seq, high_surrogate());
      if ($urandom_range(0, 1)) begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_BSLASH);
        seq.push_back(b);
      end else begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_LOW_U);
        seq.push_back(CH_BSLASH);
        seq.push_back(b);
      end
    end else if (pick < 90) begin
      do b = 8'($urandom_range(0, 255));
      while (b inside {CH_LOW_R, CH_LOW_N, CH_BSLASH, CH_SLASH, CH_QUOTE,
                       CH_LOW_F, CH_LOW_B, CH_LOW_T, CH_LOW_U});
      seq.push_back(CH_BSLASH);
      seq.push_back(b);
    end else if (pick < 95) begin
      if ($urandom_range(0, 1)) begin
        push_uescape(seq, 16'($urandom));
        seq[$urandom_range(2, 5)] = non_hex_byte();
      end else begin
        push_uescape(seq, high_surrogate());
        push_uescape(seq, 16'($urandom));
        seq[$urandom_range(2, 11)] = non_hex_byte();
      end
    end else begin
      // string ends in the middle of an escape
      end_here = 1'b1;
      case ($urandom_range(0, 2))
        0: seq.push_back(CH_BSLASH);
        1: begin
          push_uescape(seq, 16'($urandom));
          keep = $urandom_range(2, 5);
          while (seq.size() > keep) void'(seq.pop_back());
        end
        default: begin
          push_uescape(seq, high_surrogate());
          push_uescape(seq, 16'($urandom));
          keep = $urandom_range(6, 11);
          while (seq.size() > keep) void'(seq.pop_back());
        end
      endcase
    end
    send_seq(seq, end_here);
  endtask

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = burst_mode ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("no transfer for %0d cycles", STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes, unknown letter, code point zero, lone surrogate, bad digit,
    // string cut inside an escape
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_seq(text_bytes("\\q"), 1'b0);
    send_seq(text_bytes("\\u0000"), 1'b0);
    send_seq(text_bytes("\\uDBfFz"), 1'b0);
    send_seq(text_bytes("\\u00G9"), 1'b0);
    send_byte(CH_BSLASH, 1'b1);

    while (bytes_sent < 150) send_random_token();
    burst_mode = 1'b1;
    while (bytes_sent < 210) send_random_token();
    burst_mode = 1'b0;
    wait_drained();

    // receiver holds off while bytes keep coming back to back
    hold_req   = 1'b1;
    burst_mode = 1'b1;
    while (bytes_sent < 260) send_random_token();
    burst_mode = 1'b0;
    while (bytes_sent < ITEM_TARGET) send_random_token();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d escaped bytes, checked %0d utf-8 bytes (%0d surrogate pairs, %0d flagged)",
             bytes_sent, bytes_checked, pairs_seen, flagged_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_in_if.sv
hdl/jsu_out_if.sv
hdl/json_string_unescape_utf8.sv
dv/utf8_unescape_check.sv
dv/tb.sv
